### src/vfc_pkg.sv
// Shared types, codes, tables and helper functions of the voxel face culling mesher.
`timescale 1ns / 1ps

package vfc_pkg;

	localparam int X_W = 4;
	localparam int Y_W = 8;
	localparam int Z_W = 4;
	localparam int SIDE_W = 2;
	localparam int KIND_W = 5;
	localparam int POS_W = 10;
	localparam int LAYER_W = 10;
	localparam int NORMAL_W = 3;
	localparam int FACES = 6;
	localparam int IN_TDATA_W = 24;
	localparam int IN_TUSER_W = 2;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_W = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int KIND_MAX = 16;
	localparam int TEX_KINDS = 17;

	typedef enum logic [1:0] {
		OP_WR_CHUNK  = 2'd0,
		OP_WR_BORDER = 2'd1,
		OP_EMIT      = 2'd2
	} op_t;

	localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd0;
	localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd1;
	localparam logic [SIDE_W-1:0] SIDE_BACK  = 2'd2;
	localparam logic [SIDE_W-1:0] SIDE_FRONT = 2'd3;

	typedef enum logic [2:0] {
		FACE_LEFT   = 3'd0,
		FACE_RIGHT  = 3'd1,
		FACE_BOTTOM = 3'd2,
		FACE_TOP    = 3'd3,
		FACE_BACK   = 3'd4,
		FACE_FRONT  = 3'd5
	} face_t;

	localparam logic [NORMAL_W-1:0] NORMAL_POS_X = 3'd0;
	localparam logic [NORMAL_W-1:0] NORMAL_NEG_X = 3'd1;
	localparam logic [NORMAL_W-1:0] NORMAL_POS_Y = 3'd2;
	localparam logic [NORMAL_W-1:0] NORMAL_NEG_Y = 3'd3;
	localparam logic [NORMAL_W-1:0] NORMAL_POS_Z = 3'd4;
	localparam logic [NORMAL_W-1:0] NORMAL_NEG_Z = 3'd5;

	localparam logic [KIND_W-1:0] KIND_AIR     = 5'd0;
	localparam logic [KIND_W-1:0] KIND_WATER_A = 5'd6;
	localparam logic [KIND_W-1:0] KIND_WATER_B = 5'd13;
	localparam logic [KIND_W-1:0] KIND_WATER_C = 5'd16;

	typedef enum logic [1:0] {
		TEX_TOP    = 2'd0,
		TEX_SIDE   = 2'd1,
		TEX_BOTTOM = 2'd2
	} tex_sel_t;

	localparam logic [KIND_W-1:0] TEX_TOP_LUT [TEX_KINDS] = '{
		5'd0, 5'd2, 5'd3, 5'd0, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
		5'd9, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17
	};
	localparam logic [KIND_W-1:0] TEX_SIDE_LUT [TEX_KINDS] = '{
		5'd0, 5'd2, 5'd3, 5'd1, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
		5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17
	};
	localparam logic [KIND_W-1:0] TEX_BOTTOM_LUT [TEX_KINDS] = '{
		5'd0, 5'd2, 5'd3, 5'd2, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
		5'd11, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17
	};

	typedef struct packed {
		logic x_lo;
		logic x_hi;
		logic y_lo;
		logic y_hi;
		logic z_lo;
		logic z_hi;
	} edges_t;

	typedef struct packed {
		op_t                op;
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic [Z_W-1:0]     z;
		logic [SIDE_W-1:0]  side;
		logic [KIND_W-1:0]  kind;
		edges_t             edges;
	} req_t;

	typedef struct packed {
		logic [FACES-1:0]   faces;
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic [Z_W-1:0]     z;
		logic               water;
		logic [KIND_W-1:0]  lay_top;
		logic [KIND_W-1:0]  lay_side;
		logic [KIND_W-1:0]  lay_bottom;
	} quad_job_t;

	function automatic logic is_water(input logic [KIND_W-1:0] kind);
		return (kind == KIND_WATER_A) || (kind == KIND_WATER_B) || (kind == KIND_WATER_C);
	endfunction

	function automatic logic face_visible(input logic [KIND_W-1:0] self_kind,
			input logic [KIND_W-1:0] other_kind);
		return (other_kind == KIND_AIR) || (is_water(self_kind) != is_water(other_kind));
	endfunction

	function automatic logic [KIND_W-1:0] tex_layer(input logic [KIND_W-1:0] kind,
			input tex_sel_t sel);
		logic [KIND_W-1:0] layer;
		layer = '0;
		if (kind <= KIND_W'(KIND_MAX)) begin
			unique case (sel)
				TEX_TOP:    layer = TEX_TOP_LUT[kind];
				TEX_BOTTOM: layer = TEX_BOTTOM_LUT[kind];
				default:    layer = TEX_SIDE_LUT[kind];
			endcase
		end
		return layer;
	endfunction

	function automatic logic [NORMAL_W-1:0] normal_of(input face_t face);
		logic [NORMAL_W-1:0] nrm;
		unique case (face)
			FACE_LEFT:   nrm = NORMAL_NEG_X;
			FACE_RIGHT:  nrm = NORMAL_POS_X;
			FACE_BOTTOM: nrm = NORMAL_NEG_Y;
			FACE_TOP:    nrm = NORMAL_POS_Y;
			FACE_BACK:   nrm = NORMAL_NEG_Z;
			default:     nrm = NORMAL_POS_Z;
		endcase
		return nrm;
	endfunction

endpackage

### src/vfc_front.sv
// Input decoder: unpacks an item, drops unused or out-of-chunk requests and flags chunk edges.
`timescale 1ns / 1ps

module vfc_front #(
	parameter int CHUNK_WIDTH = 16,
	parameter int CHUNK_TALL  = 256
) (
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [vfc_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [vfc_pkg::IN_TUSER_W-1:0]   s_tuser,
	output logic                             q_valid,
	input  logic                             q_ready,
	output vfc_pkg::req_t                    q_req
);

	logic [vfc_pkg::X_W-1:0] x;
	logic [vfc_pkg::Y_W-1:0] y;
	logic [vfc_pkg::Z_W-1:0] z;
	logic                    in_range;
	logic                    known_op;

	assign x = s_tdata[3:0];
	assign y = s_tdata[11:4];
	assign z = s_tdata[15:12];

	assign in_range = (32'(x) < CHUNK_WIDTH) && (32'(z) < CHUNK_WIDTH) && (32'(y) < CHUNK_TALL);

	always_comb begin
		unique case (vfc_pkg::op_t'(s_tuser))
			vfc_pkg::OP_WR_CHUNK, vfc_pkg::OP_WR_BORDER, vfc_pkg::OP_EMIT: known_op = 1'b1;
			default: known_op = 1'b0;
		endcase
	end

	always_comb begin
		q_req            = '0;
		q_req.op         = vfc_pkg::op_t'(s_tuser);
		q_req.x          = x;
		q_req.y          = y;
		q_req.z          = z;
		q_req.side       = s_tdata[17:16];
		q_req.kind       = s_tdata[22:18];
		q_req.edges.x_lo = (x == '0);
		q_req.edges.x_hi = (32'(x) + 1 >= CHUNK_WIDTH);
		q_req.edges.y_lo = (y == '0);
		q_req.edges.y_hi = (32'(y) + 1 >= CHUNK_TALL);
		q_req.edges.z_lo = (z == '0);
		q_req.edges.z_hi = (32'(z) + 1 >= CHUNK_WIDTH);
	end

	// Dropped items are still taken, but only while the queue has room, as s_tready follows q_ready.
	assign s_tready = q_ready;
	assign q_valid  = s_tvalid && in_range && known_op;

endmodule

### src/vfc_queue.sv
// Short request queue between the decoder and the store sequencer.
`timescale 1ns / 1ps

module vfc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  vfc_pkg::req_t in_req,
	output logic          out_valid,
	input  logic          out_ready,
	output vfc_pkg::req_t out_req
);

	localparam int PTR_W = $clog2(vfc_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(vfc_pkg::QUEUE_DEPTH + 1);

	vfc_pkg::req_t     entry_q [vfc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign in_ready  = (count_q != CNT_W'(vfc_pkg::QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_req   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(vfc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(vfc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_req;
		end
	end

endmodule

### src/vfc_fetch.sv
// Store sequencer: holds the chunk and border memories, performs writes and gathers neighbours.
`timescale 1ns / 1ps

module vfc_fetch #(
	parameter int CHUNK_WIDTH = 16,
	parameter int CHUNK_TALL  = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [vfc_pkg::CFG_W-1:0]   present_mask,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  vfc_pkg::req_t               q_req,
	output logic                        job_valid,
	input  logic                        job_ready,
	output vfc_pkg::quad_job_t          job
);

	localparam int SLICE  = CHUNK_TALL * CHUNK_WIDTH;
	localparam int VOXELS = CHUNK_WIDTH * SLICE;
	localparam int AW     = $clog2(VOXELS);
	localparam int SAW    = $clog2(SLICE);
	localparam int BAW    = $clog2(4 * SLICE);
	localparam int KW     = vfc_pkg::KIND_W;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_WR   = 7'b0000010,
		ST_RD0  = 7'b0000100,
		ST_RD1  = 7'b0001000,
		ST_RD2  = 7'b0010000,
		ST_RD3  = 7'b0100000,
		ST_EVAL = 7'b1000000
	} state_t;

	state_t          state_q;
	vfc_pkg::req_t   cur_q;
	logic [AW-1:0]   base_q;
	logic [SAW-1:0]  ywz_q;
	logic [SAW-1:0]  ywx_q;
	logic [KW-1:0]   chunk_mem [VOXELS];
	logic [KW-1:0]   border_mem [4 * SLICE];
	logic [KW-1:0]   ra_q;
	logic [KW-1:0]   rb_q;
	logic [KW-1:0]   rc_q;
	logic [KW-1:0]   self_q;
	logic [KW-1:0]   nb_q [5];
	logic [KW-1:0]   nb_front;
	logic [AW-1:0]   addr_a;
	logic [AW-1:0]   addr_b;
	logic [BAW-1:0]  addr_c;
	logic [BAW-1:0]  wr_baddr;
	logic [SAW-1:0]  wr_along;
	logic [vfc_pkg::FACES-1:0] faces;
	logic            has_quads;
	logic            free;
	logic            pop;
	logic            wr_chunk;
	logic            wr_border;

	function automatic logic [KW-1:0] border_kind(input logic present, input logic [KW-1:0] kind);
		return present ? kind : vfc_pkg::KIND_AIR;
	endfunction

	assign wr_chunk  = (state_q == ST_WR) && (cur_q.op == vfc_pkg::OP_WR_CHUNK);
	assign wr_border = (state_q == ST_WR) && (cur_q.op == vfc_pkg::OP_WR_BORDER);
	assign wr_along  = ((cur_q.side == vfc_pkg::SIDE_LEFT) || (cur_q.side == vfc_pkg::SIDE_RIGHT))
			? ywz_q : ywx_q;
	assign wr_baddr  = BAW'(32'(cur_q.side) * SLICE + 32'(wr_along));

	always_comb begin
		unique case (state_q)
			ST_RD0: begin
				addr_a = base_q;
				addr_b = base_q - AW'(SLICE);
				addr_c = BAW'(ywz_q);
			end
			ST_RD1: begin
				addr_a = base_q - AW'(CHUNK_WIDTH);
				addr_b = base_q + AW'(SLICE);
				addr_c = BAW'(SLICE) + BAW'(ywz_q);
			end
			ST_RD2: begin
				addr_a = base_q + AW'(CHUNK_WIDTH);
				addr_b = base_q - AW'(1);
				addr_c = BAW'(2 * SLICE) + BAW'(ywx_q);
			end
			default: begin
				addr_a = base_q;
				addr_b = base_q + AW'(1);
				addr_c = BAW'(3 * SLICE) + BAW'(ywx_q);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ra_q <= chunk_mem[addr_a];
		rb_q <= chunk_mem[addr_b];
		if (wr_chunk) begin
			chunk_mem[base_q] <= cur_q.kind;
		end
	end

	always_ff @(posedge clk) begin
		rc_q <= border_mem[addr_c];
		if (wr_border) begin
			border_mem[wr_baddr] <= cur_q.kind;
		end
	end

	assign nb_front = cur_q.edges.z_hi ? border_kind(present_mask[3], rc_q) : rb_q;

	always_comb begin
		faces[0] = vfc_pkg::face_visible(self_q, nb_q[0]);
		faces[1] = vfc_pkg::face_visible(self_q, nb_q[1]);
		faces[2] = cur_q.edges.y_lo || vfc_pkg::face_visible(self_q, nb_q[2]);
		faces[3] = cur_q.edges.y_hi || vfc_pkg::face_visible(self_q, nb_q[3]);
		faces[4] = vfc_pkg::face_visible(self_q, nb_q[4]);
		faces[5] = vfc_pkg::face_visible(self_q, nb_front);
	end

	assign has_quads = (self_q != vfc_pkg::KIND_AIR) && (faces != '0);
	assign job_valid = (state_q == ST_EVAL) && has_quads;

	always_comb begin
		job            = '0;
		job.faces      = faces;
		job.x          = cur_q.x;
		job.y          = cur_q.y;
		job.z          = cur_q.z;
		job.water      = vfc_pkg::is_water(self_q);
		job.lay_top    = vfc_pkg::tex_layer(self_q, vfc_pkg::TEX_TOP);
		job.lay_side   = vfc_pkg::tex_layer(self_q, vfc_pkg::TEX_SIDE);
		job.lay_bottom = vfc_pkg::tex_layer(self_q, vfc_pkg::TEX_BOTTOM);
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE, ST_WR: free = 1'b1;
			ST_EVAL:        free = !has_quads || job_ready;
			default:        free = 1'b0;
		endcase
	end

	assign q_ready = free;
	assign pop     = q_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_RD3;
				ST_RD3: state_q <= ST_EVAL;
				default: begin
					if (pop) begin
						state_q <= (q_req.op == vfc_pkg::OP_EMIT) ? ST_RD0 : ST_WR;
					end else if (free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= q_req;
			base_q <= AW'(32'(q_req.x) * SLICE + 32'(q_req.y) * CHUNK_WIDTH + 32'(q_req.z));
			ywz_q  <= SAW'(32'(q_req.y) * CHUNK_WIDTH + 32'(q_req.z));
			ywx_q  <= SAW'(32'(q_req.y) * CHUNK_WIDTH + 32'(q_req.x));
		end
		if (state_q == ST_RD1) begin
			self_q   <= ra_q;
			nb_q[0]  <= cur_q.edges.x_lo ? border_kind(present_mask[0], rc_q) : rb_q;
		end
		if (state_q == ST_RD2) begin
			nb_q[2]  <= ra_q;
			nb_q[1]  <= cur_q.edges.x_hi ? border_kind(present_mask[1], rc_q) : rb_q;
		end
		if (state_q == ST_RD3) begin
			nb_q[3]  <= ra_q;
			nb_q[4]  <= cur_q.edges.z_lo ? border_kind(present_mask[2], rc_q) : rb_q;
		end
	end

endmodule

### src/vfc_emit.sv
// Quad emitter: walks the visible faces of a job and drives the registered result stream.
`timescale 1ns / 1ps

module vfc_emit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_valid,
	output logic                             job_ready,
	input  vfc_pkg::quad_job_t               job,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [vfc_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                             m_tuser,
	output logic                             m_tlast
);

	localparam int PW = vfc_pkg::POS_W;

	vfc_pkg::quad_job_t        job_q;
	logic [vfc_pkg::FACES-1:0] pend_q;
	logic [vfc_pkg::FACES-1:0] pick;
	logic [vfc_pkg::FACES-1:0] pend_left;
	logic [vfc_pkg::FACES-1:0] pend_after;
	vfc_pkg::face_t            face;
	logic                      out_free;
	logic                      advance;
	logic                      m_tvalid_q;
	logic [vfc_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic                      m_tuser_q;
	logic                      m_tlast_q;
	logic [PW-1:0]             pos_x;
	logic [PW-1:0]             pos_y;
	logic [PW-1:0]             pos_z;
	logic [vfc_pkg::KIND_W-1:0] layer;

	// The lowest pending face goes first, which keeps left, right, bottom, top, back, front order.
	always_comb begin
		pick = '0;
		face = vfc_pkg::FACE_LEFT;
		for (int f = vfc_pkg::FACES - 1; f >= 0; f--) begin
			if (pend_q[f]) begin
				pick = vfc_pkg::FACES'(1) << f;
				face = vfc_pkg::face_t'(3'(f));
			end
		end
	end

	assign pend_left  = pend_q & ~pick;
	assign out_free   = !m_tvalid_q || m_tready;
	assign advance    = out_free && (pend_q != '0);
	assign pend_after = advance ? pend_left : pend_q;
	assign job_ready  = (pend_after == '0);

	assign pos_x = PW'(job_q.x) + PW'(face == vfc_pkg::FACE_RIGHT);
	assign pos_y = PW'(job_q.y) + PW'(face == vfc_pkg::FACE_TOP);
	assign pos_z = PW'(job_q.z) + PW'(face == vfc_pkg::FACE_FRONT);

	always_comb begin
		case (face)
			vfc_pkg::FACE_TOP:    layer = job_q.lay_top;
			vfc_pkg::FACE_BOTTOM: layer = job_q.lay_bottom;
			default:              layer = job_q.lay_side;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (job_valid && job_ready) begin
				pend_q <= job.faces;
			end else begin
				pend_q <= pend_after;
			end
			if (advance) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q <= job;
		end
		if (advance) begin
			m_tdata_q <= {5'b0, vfc_pkg::normal_of(face), vfc_pkg::LAYER_W'(layer),
					pos_z, pos_y, pos_x};
			m_tuser_q <= job_q.water;
			m_tlast_q <= (pend_left == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

### src/voxel_face_cull_mesher.sv
// Top level of the voxel face culling mesher: ports, configuration register and block wiring.
`timescale 1ns / 1ps

// Chunk and border writes are taken at one item per cycle while the queue has room. An emit item
// occupies the store sequencer through the read states RD0 to RD3, on the two read ports of the
// chunk memory with the border memory read alongside, and then the evaluate state for the six
// faces, which holds while the emitter cannot yet take a job that has quads. Quads then leave
// at one per cycle from a registered output while the receiver is ready. A four-item queue
// between the input decoder and the sequencer lets writes arrive while an emit is still reading.
// Neither store is cleared; a voxel must be written before it, or a face next to it, is emitted.
module voxel_face_cull_mesher #(
	parameter int CHUNK_WIDTH = 16,
	parameter int CHUNK_TALL  = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [vfc_pkg::CFG_W-1:0]        cfg_data,     // neighbor_present_mask
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// voxel_x[3:0], voxel_y[11:4], voxel_z[15:12], border_side[17:16], block_kind[22:18]
	input  logic [vfc_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [vfc_pkg::IN_TUSER_W-1:0]   s_tuser,      // req_type
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// packed_position[29:0], packed_attributes[42:30]
	output logic [vfc_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                             m_tuser,      // translucent
	output logic                             m_tlast       // last_of_run
);

	logic [vfc_pkg::CFG_W-1:0] present_mask_q;
	logic                      fq_valid;
	logic                      fq_ready;
	vfc_pkg::req_t             fq_req;
	logic                      qs_valid;
	logic                      qs_ready;
	vfc_pkg::req_t             qs_req;
	logic                      job_valid;
	logic                      job_ready;
	vfc_pkg::quad_job_t        job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			present_mask_q <= cfg_data;
		end
	end

	vfc_front #(
		.CHUNK_WIDTH(CHUNK_WIDTH),
		.CHUNK_TALL (CHUNK_TALL)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_req   (fq_req)
	);

	vfc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fq_valid),
		.in_ready (fq_ready),
		.in_req   (fq_req),
		.out_valid(qs_valid),
		.out_ready(qs_ready),
		.out_req  (qs_req)
	);

	vfc_fetch #(
		.CHUNK_WIDTH(CHUNK_WIDTH),
		.CHUNK_TALL (CHUNK_TALL)
	) u_fetch (
		.clk         (clk),
		.arst_n      (arst_n),
		.present_mask(present_mask_q),
		.q_valid     (qs_valid),
		.q_ready     (qs_ready),
		.q_req       (qs_req),
		.job_valid   (job_valid),
		.job_ready   (job_ready),
		.job         (job)
	);

	vfc_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### sim/voxel_face_cull_mesher_tb.sv
// Self-checking testbench of the voxel face culling mesher with its own face predictor.
`timescale 1ns / 1ps

module voxel_face_cull_mesher_tb;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int VOXELS = 1 << (vfc_pkg::X_W + vfc_pkg::Y_W + vfc_pkg::Z_W);
	localparam int BORDER_CELLS = 4 << (vfc_pkg::Y_W + vfc_pkg::Z_W);

	typedef struct packed {
		logic [29:0] position;
		logic [12:0] attributes;
		logic        translucent;
		logic        last;
	} quad_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [vfc_pkg::CFG_W-1:0]           cfg_data = '0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [vfc_pkg::IN_TDATA_W-1:0]      s_tdata = '0;
	logic [vfc_pkg::IN_TUSER_W-1:0]      s_tuser = '0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [vfc_pkg::OUT_TDATA_W-1:0]     m_tdata;
	logic                                m_tuser;
	logic                                m_tlast;

	logic [vfc_pkg::KIND_W-1:0] chunk_kind [0:VOXELS-1];
	bit                         chunk_set [0:VOXELS-1];
	logic [vfc_pkg::KIND_W-1:0] border_kind [0:BORDER_CELLS-1];
	bit                         border_set [0:BORDER_CELLS-1];
	logic [vfc_pkg::CFG_W-1:0]  present_mask = '0;
	quad_t                      quads_due [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int items_sent = 0;
	int emits_sent = 0;
	int quads_checked = 0;
	int masks_written = 0;

	voxel_face_cull_mesher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic logic [15:0] voxel_addr(input logic [vfc_pkg::X_W-1:0] x,
			input logic [vfc_pkg::Y_W-1:0] y, input logic [vfc_pkg::Z_W-1:0] z);
		return {x, y, z};
	endfunction

	function automatic logic [13:0] border_addr(input logic [vfc_pkg::SIDE_W-1:0] side,
			input logic [vfc_pkg::Y_W-1:0] y, input logic [3:0] along);
		return {side, y, along};
	endfunction

	function automatic logic is_translucent(input logic [vfc_pkg::KIND_W-1:0] kind);
		return kind == vfc_pkg::KIND_WATER_A || kind == vfc_pkg::KIND_WATER_B
			|| kind == vfc_pkg::KIND_WATER_C;
	endfunction

	function automatic logic [9:0] layer_of_kind(input logic [vfc_pkg::KIND_W-1:0] kind,
			input vfc_pkg::tex_sel_t sel);
		if (kind > 5'd16)
			return 10'd0;
		case (kind)
			5'd0: return 10'd0;
			5'd1: return 10'd2;
			5'd2: return 10'd3;
			5'd3: return (sel == vfc_pkg::TEX_TOP) ? 10'd0
				: (sel == vfc_pkg::TEX_SIDE) ? 10'd1 : 10'd2;
			5'd9: return (sel == vfc_pkg::TEX_TOP) ? 10'd9
				: (sel == vfc_pkg::TEX_SIDE) ? 10'd10 : 10'd11;
			default: return (kind < 5'd9) ? 10'(kind) : 10'(kind) + 10'd1;
		endcase
	endfunction

	function automatic logic [vfc_pkg::KIND_W-1:0] border_read(
			input logic [vfc_pkg::SIDE_W-1:0] side, input logic [vfc_pkg::Y_W-1:0] y,
			input logic [3:0] along);
		if (!present_mask[side])
			return vfc_pkg::KIND_AIR;
		return border_kind[border_addr(side, y, along)];
	endfunction

	function automatic void predict_quads(input logic [vfc_pkg::X_W-1:0] x,
			input logic [vfc_pkg::Y_W-1:0] y, input logic [vfc_pkg::Z_W-1:0] z);
		logic [vfc_pkg::KIND_W-1:0]   self_kind;
		logic [vfc_pkg::KIND_W-1:0]   beyond;
		logic [9:0]                   cx, cy, cz, layer;
		logic [vfc_pkg::NORMAL_W-1:0] nrm;
		vfc_pkg::face_t               face;
		quad_t                        quad;
		quad_t                        run [$];
		int                           i;
		self_kind = chunk_kind[voxel_addr(x, y, z)];
		if (self_kind == vfc_pkg::KIND_AIR)
			return;
		for (i = 0; i < vfc_pkg::FACES; i++) begin
			face = vfc_pkg::face_t'(i);
			cx = 10'(x);
			cy = 10'(y);
			cz = 10'(z);
			layer = layer_of_kind(self_kind, vfc_pkg::TEX_SIDE);
			case (face)
				vfc_pkg::FACE_LEFT: begin
					beyond = (x == 0) ? border_read(vfc_pkg::SIDE_LEFT, y, z)
						: chunk_kind[voxel_addr(x - 1'b1, y, z)];
					nrm = vfc_pkg::NORMAL_NEG_X;
				end
				vfc_pkg::FACE_RIGHT: begin
					beyond = (&x) ? border_read(vfc_pkg::SIDE_RIGHT, y, z)
						: chunk_kind[voxel_addr(x + 1'b1, y, z)];
					nrm = vfc_pkg::NORMAL_POS_X;
					cx = 10'(x) + 10'd1;
				end
				vfc_pkg::FACE_BOTTOM: begin
					beyond = (y == 0) ? vfc_pkg::KIND_AIR
						: chunk_kind[voxel_addr(x, y - 1'b1, z)];
					nrm = vfc_pkg::NORMAL_NEG_Y;
					layer = layer_of_kind(self_kind, vfc_pkg::TEX_BOTTOM);
				end
				vfc_pkg::FACE_TOP: begin
					beyond = (&y) ? vfc_pkg::KIND_AIR
						: chunk_kind[voxel_addr(x, y + 1'b1, z)];
					nrm = vfc_pkg::NORMAL_POS_Y;
					layer = layer_of_kind(self_kind, vfc_pkg::TEX_TOP);
					cy = 10'(y) + 10'd1;
				end
				vfc_pkg::FACE_BACK: begin
					beyond = (z == 0) ? border_read(vfc_pkg::SIDE_BACK, y, x)
						: chunk_kind[voxel_addr(x, y, z - 1'b1)];
					nrm = vfc_pkg::NORMAL_NEG_Z;
				end
				default: begin
					beyond = (&z) ? border_read(vfc_pkg::SIDE_FRONT, y, x)
						: chunk_kind[voxel_addr(x, y, z + 1'b1)];
					nrm = vfc_pkg::NORMAL_POS_Z;
					cz = 10'(z) + 10'd1;
				end
			endcase
			if (beyond == vfc_pkg::KIND_AIR
					|| is_translucent(self_kind) != is_translucent(beyond)) begin
				quad.position = {cz, cy, cx};
				quad.attributes = {nrm, layer};
				quad.translucent = is_translucent(self_kind);
				quad.last = 1'b0;
				run.push_back(quad);
			end
		end
		foreach (run[j]) begin
			quad = run[j];
			quad.last = (j == run.size() - 1);
			quads_due.push_back(quad);
		end
	endfunction

	function automatic logic [vfc_pkg::KIND_W-1:0] random_kind();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25)
			return vfc_pkg::KIND_AIR;
		if (pick < 50)
			case ($urandom_range(2))
				0: return vfc_pkg::KIND_WATER_A;
				1: return vfc_pkg::KIND_WATER_B;
				default: return vfc_pkg::KIND_WATER_C;
			endcase
		if (pick < 85)
			return vfc_pkg::KIND_W'($urandom_range(16, 1));
		return vfc_pkg::KIND_W'($urandom_range(31, 17));
	endfunction

	function automatic int edge_or_any(input int top);
		if ($urandom_range(1))
			return $urandom_range(1) ? top : 0;
		return $urandom_range(top);
	endfunction

	function automatic int nudge(input int v, input int top);
		int n;
		n = $urandom_range(1) ? v + 1 : v - 1;
		return (n < 0) ? 1 : (n > top) ? top - 1 : n;
	endfunction

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// The item is taken at the edge that follows a falling edge seeing both valid and ready.
	task automatic send_item(input logic [1:0] op, input logic [vfc_pkg::X_W-1:0] x,
			input logic [vfc_pkg::Y_W-1:0] y, input logic [vfc_pkg::Z_W-1:0] z,
			input logic [vfc_pkg::SIDE_W-1:0] side, input logic [vfc_pkg::KIND_W-1:0] kind);
		bit         taken;
		logic [3:0] along;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, kind, side, z, y, x};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		items_sent++;
		case (op)
			vfc_pkg::OP_WR_CHUNK: begin
				chunk_kind[voxel_addr(x, y, z)] = kind;
				chunk_set[voxel_addr(x, y, z)] = 1'b1;
			end
			vfc_pkg::OP_WR_BORDER: begin
				along = (side == vfc_pkg::SIDE_LEFT || side == vfc_pkg::SIDE_RIGHT) ? z : x;
				border_kind[border_addr(side, y, along)] = kind;
				border_set[border_addr(side, y, along)] = 1'b1;
			end
			vfc_pkg::OP_EMIT: predict_quads(x, y, z);
			default: ;
		endcase
	endtask

	task automatic write_voxel(input logic [vfc_pkg::X_W-1:0] x, input logic [vfc_pkg::Y_W-1:0] y,
			input logic [vfc_pkg::Z_W-1:0] z, input logic [vfc_pkg::KIND_W-1:0] kind);
		send_item(vfc_pkg::OP_WR_CHUNK, x, y, z, vfc_pkg::SIDE_W'($urandom_range(3)), kind);
	endtask

	task automatic write_border(input logic [vfc_pkg::SIDE_W-1:0] side,
			input logic [vfc_pkg::Y_W-1:0] y, input logic [3:0] along,
			input logic [vfc_pkg::KIND_W-1:0] kind);
		if (side == vfc_pkg::SIDE_LEFT || side == vfc_pkg::SIDE_RIGHT)
			send_item(vfc_pkg::OP_WR_BORDER, vfc_pkg::X_W'($urandom_range(15)), y, along,
				side, kind);
		else
			send_item(vfc_pkg::OP_WR_BORDER, along, y, vfc_pkg::Z_W'($urandom_range(15)),
				side, kind);
	endtask

	task automatic ensure_voxel(input logic [vfc_pkg::X_W-1:0] x,
			input logic [vfc_pkg::Y_W-1:0] y, input logic [vfc_pkg::Z_W-1:0] z);
		if (!chunk_set[voxel_addr(x, y, z)])
			write_voxel(x, y, z, random_kind());
	endtask

	task automatic ensure_border(input logic [vfc_pkg::SIDE_W-1:0] side,
			input logic [vfc_pkg::Y_W-1:0] y, input logic [3:0] along);
		if (!border_set[border_addr(side, y, along)])
			write_border(side, y, along, random_kind());
	endtask

	// Every cell the emit may look at is given a kind first, border cells of absent sides too.
	task automatic emit_voxel(input logic [vfc_pkg::X_W-1:0] x,
			input logic [vfc_pkg::Y_W-1:0] y, input logic [vfc_pkg::Z_W-1:0] z);
		ensure_voxel(x, y, z);
		if (x == 0)
			ensure_border(vfc_pkg::SIDE_LEFT, y, z);
		else
			ensure_voxel(x - 1'b1, y, z);
		if (&x)
			ensure_border(vfc_pkg::SIDE_RIGHT, y, z);
		else
			ensure_voxel(x + 1'b1, y, z);
		if (y != 0)
			ensure_voxel(x, y - 1'b1, z);
		if (!(&y))
			ensure_voxel(x, y + 1'b1, z);
		if (z == 0)
			ensure_border(vfc_pkg::SIDE_BACK, y, x);
		else
			ensure_voxel(x, y, z - 1'b1);
		if (&z)
			ensure_border(vfc_pkg::SIDE_FRONT, y, x);
		else
			ensure_voxel(x, y, z + 1'b1);
		send_item(vfc_pkg::OP_EMIT, x, y, z, vfc_pkg::SIDE_W'($urandom_range(3)),
			vfc_pkg::KIND_W'($urandom_range(31)));
		emits_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (quads_due.size() != 0)
			@(posedge clk);
	endtask

	// Emits of air cells and writes leave no quad behind, so the queue inside may still be busy.
	task automatic settle();
		wait_drained();
		repeat (40) @(posedge clk);
	endtask

	task automatic write_mask(input logic [vfc_pkg::CFG_W-1:0] value);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		present_mask = value;
		masks_written++;
	endtask

	task automatic test_corner_faces();
		write_voxel(4'd0, 8'd0, 4'd0, 5'd3);
		write_voxel(4'd1, 8'd0, 4'd0, vfc_pkg::KIND_WATER_A);
		write_voxel(4'd0, 8'd1, 4'd0, 5'd1);
		write_voxel(4'd0, 8'd0, 4'd1, vfc_pkg::KIND_WATER_C);
		write_border(vfc_pkg::SIDE_LEFT, 8'd0, 4'd0, 5'd2);
		write_border(vfc_pkg::SIDE_BACK, 8'd0, 4'd0, vfc_pkg::KIND_AIR);
		emit_voxel(4'd0, 8'd0, 4'd0);
		write_voxel(4'd15, 8'd255, 4'd15, 5'd31);
		write_voxel(4'd14, 8'd255, 4'd15, 5'd31);
		write_voxel(4'd15, 8'd254, 4'd15, vfc_pkg::KIND_WATER_B);
		write_voxel(4'd15, 8'd255, 4'd14, 5'd31);
		write_border(vfc_pkg::SIDE_RIGHT, 8'd255, 4'd15, 5'd5);
		write_border(vfc_pkg::SIDE_FRONT, 8'd255, 4'd15, vfc_pkg::KIND_WATER_C);
		emit_voxel(4'd15, 8'd255, 4'd15);
	endtask

	task automatic test_water_and_air();
		emit_voxel(4'd0, 8'd0, 4'd1);
		write_voxel(4'd0, 8'd0, 4'd1, vfc_pkg::KIND_AIR);
		emit_voxel(4'd0, 8'd0, 4'd1);
	endtask

	task automatic test_unused_request();
		send_item(REQ_NONE, 4'd15, 8'd255, 4'd15, vfc_pkg::SIDE_FRONT, 5'd31);
		send_item(REQ_NONE, 4'd0, 8'd0, 4'd0, vfc_pkg::SIDE_LEFT, vfc_pkg::KIND_AIR);
	endtask

	task automatic test_neighbour_masks();
		logic [vfc_pkg::CFG_W-1:0] masks [6];
		masks = '{4'hF, 4'h1, 4'h2, 4'h4, 4'h8, 4'h0};
		foreach (masks[i]) begin
			settle();
			write_mask(masks[i]);
			emit_voxel(4'd0, 8'd0, 4'd0);
			emit_voxel(4'd15, 8'd255, 4'd15);
			emit_voxel(4'd0, 8'd0, 4'd1);
		end
	endtask

	// Mostly emits around a wandering cell, so that neighbours are shared and rewritten.
	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int quota);
		int                         first;
		int                         pick;
		logic [vfc_pkg::X_W-1:0]    x;
		logic [vfc_pkg::Y_W-1:0]    y;
		logic [vfc_pkg::Z_W-1:0]    z;
		settle();
		write_mask(vfc_pkg::CFG_W'($urandom_range(15)));
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		x = vfc_pkg::X_W'($urandom_range(15));
		y = vfc_pkg::Y_W'($urandom_range(255));
		z = vfc_pkg::Z_W'($urandom_range(15));
		first = items_sent;
		while (items_sent - first < quota) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				pick = $urandom_range(99);
				if (pick < 40) begin
					case ($urandom_range(2))
						0: x = vfc_pkg::X_W'(nudge(x, 15));
						1: y = vfc_pkg::Y_W'(nudge(y, 255));
						default: z = vfc_pkg::Z_W'(nudge(z, 15));
					endcase
				end else if (pick < 60) begin
					x = vfc_pkg::X_W'(edge_or_any(15));
					y = vfc_pkg::Y_W'(edge_or_any(255));
					z = vfc_pkg::Z_W'(edge_or_any(15));
				end else begin
					x = vfc_pkg::X_W'($urandom_range(15));
					y = vfc_pkg::Y_W'($urandom_range(255));
					z = vfc_pkg::Z_W'($urandom_range(15));
				end
				if ($urandom_range(1))
					write_voxel(x, y, z, random_kind());
				emit_voxel(x, y, z);
				if ($urandom_range(19) == 0)
					wait_drained();
			end else if (pick < 82) begin
				write_voxel(vfc_pkg::X_W'($urandom_range(15)), vfc_pkg::Y_W'($urandom_range(255)),
					vfc_pkg::Z_W'($urandom_range(15)), random_kind());
			end else if (pick < 94) begin
				write_border(vfc_pkg::SIDE_W'($urandom_range(3)),
					vfc_pkg::Y_W'($urandom_range(255)), 4'($urandom_range(15)), random_kind());
			end else begin
				send_item(REQ_NONE, vfc_pkg::X_W'($urandom_range(15)),
					vfc_pkg::Y_W'($urandom_range(255)), vfc_pkg::Z_W'($urandom_range(15)),
					vfc_pkg::SIDE_W'($urandom_range(3)), vfc_pkg::KIND_W'($urandom_range(31)));
			end
		end
	endtask

	always @(posedge clk)
		m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

	always @(negedge clk) begin : take_quad
		quad_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (quads_due.size() == 0) begin
				report_mismatch("quad with nothing due", m_tdata, 48'd0);
			end else begin
				want = quads_due.pop_front();
				quads_checked++;
				if (m_tdata[29:0] !== want.position)
					report_mismatch("position", 48'(m_tdata[29:0]), 48'(want.position));
				if (m_tdata[42:30] !== want.attributes)
					report_mismatch("attributes", 48'(m_tdata[42:30]), 48'(want.attributes));
				if (m_tuser !== want.translucent)
					report_mismatch("translucent", 48'(m_tuser), 48'(want.translucent));
				if (m_tlast !== want.last)
					report_mismatch("last of run", 48'(m_tlast), 48'(want.last));
			end
		end
	end

	initial begin
		int guard;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_faces();
		test_water_and_air();
		test_unused_request();
		test_neighbour_masks();
		test_random_traffic(0, 0, 45);
		test_random_traffic(56, 0, 45);
		test_random_traffic(0, 56, 45);
		test_random_traffic(33, 33, 45);
		s_tvalid <= 1'b0;
		for (guard = 0; guard < 5000 && quads_due.size() != 0; guard++)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (quads_due.size() != 0)
			report_mismatch("quads never emitted", 48'(quads_due.size()), 48'd0);
		$display("Summary: %0d items (%0d emits), %0d quads checked, %0d mask settings,",
			items_sent, emits_sent, quads_checked, masks_written);
		$display("Summary: idling none, sender only, receiver only and both; %0d mismatches.",
			mismatch_count);
		if (mismatch_count == 0)
			$display("voxel_face_cull_mesher_tb: done, clean");
		else
			$display("voxel_face_cull_mesher_tb: done, errors");
		$finish;
	end

	initial begin
		#3000000;
		$display("voxel_face_cull_mesher_tb: done, errors");
		$finish;
	end

endmodule
